@@ hdl/gda_pkg.sv @@
`default_nettype none

package gda_pkg;

	// Width of the day count that takes part in add-days
	localparam int CountWidth = 16;
	// Width of the shared subtractor: wide enough for the count and for the year residue
	localparam int AluW = (CountWidth > 10) ? CountWidth : 10;

	localparam logic [14:0] YearMax = 15'd32767;
	localparam logic [9:0] YearCycle = 10'd400;

	// Operation codes
	localparam logic FuncAddDays = 1'b0;
	localparam logic FuncAddMonth = 1'b1;

	// Status codes
	localparam logic [1:0] StatusOk = 2'd0;
	localparam logic [1:0] StatusInvalid = 2'd1;
	localparam logic [1:0] StatusOverflow = 2'd2;

	localparam logic [3:0] MonthJan = 4'd1;
	localparam logic [3:0] MonthFeb = 4'd2;
	localparam logic [3:0] MonthDec = 4'd12;

	typedef struct packed {
		logic borrow;
		logic [AluW-1:0] diff;
	} alu_res_t;

	// Leap year from the year taken modulo 400
	function automatic logic leap_of(input logic [8:0] r400);
		logic century;
		century = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
		return (r400[1:0] == 2'b00) && !century;
	endfunction

	// Length of a month; zero for a month code that means nothing
	function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		unique case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

@@ hdl/gda_alu.sv @@
`default_nettype none

module gda_alu (
	input wire logic [gda_pkg::AluW-1:0] a,
	input wire logic [gda_pkg::AluW-1:0] b,
	output gda_pkg::alu_res_t res
);

	logic [gda_pkg::AluW:0] wide;

	// Subtract and report borrow, which doubles as a less-than compare
	assign wide = {1'b0, a} - {1'b0, b};
	assign res.borrow = wide[gda_pkg::AluW];
	assign res.diff = wide[gda_pkg::AluW-1:0];

endmodule

`default_nettype wire

@@ hdl/gregorian_date_advance.sv @@
`default_nettype none

// Gregorian date advance. A word is taken when start is high and busy is low;
// the block then holds busy until the result word appears on out_year,
// out_month, out_day and status for exactly one cycle with done high. The
// receiver cannot stall: catch the word in the cycle done is high. Each word
// first reduces the year modulo 400 (one bit per cycle through the shared
// subtractor) and then checks the date; add-one-month and invalid dates
// finish at the check. Add-days then steps one whole month per cycle through
// the same subtractor until the remaining count ends inside the current month.
// A result past 31 December 32767 saturates there with status 2; an invalid
// input date echoes the input with status 1.
module gregorian_date_advance (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic func,
	input wire logic [14:0] in_year,
	input wire logic [3:0] in_month,
	input wire logic [4:0] in_day,
	input wire logic [gda_pkg::CountWidth-1:0] day_count,
	output logic done,
	output logic [14:0] out_year,
	output logic [3:0] out_month,
	output logic [4:0] out_day,
	output logic [1:0] status
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOD = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;
	localparam logic [1:0] S_STEP = 2'd3;

	logic [1:0] state_q, state_nx;
	logic done_q;
	logic func_q;
	logic [14:0] year_q, year_nx;
	logic [3:0] month_q, month_nx;
	logic [4:0] day_q, day_nx;
	logic [gda_pkg::CountWidth-1:0] left_q, left_nx;
	logic [8:0] rem_q, rem_nx;
	logic [3:0] bit_q;
	logic [14:0] out_year_q;
	logic [3:0] out_month_q;
	logic [4:0] out_day_q;
	logic [1:0] status_q;

	logic fin;
	logic [14:0] fin_year;
	logic [3:0] fin_month;
	logic [4:0] fin_day;
	logic [1:0] fin_status;

	logic [gda_pkg::AluW-1:0] alu_a, alu_b;
	gda_pkg::alu_res_t alu_res;
	logic [9:0] rem2;
	logic leap;
	logic [4:0] len, len_next;
	logic [5:0] rest1;
	logic [8:0] rem_inc;
	logic accept;

	gda_alu u_alu (
		.a(alu_a),
		.b(alu_b),
		.res(alu_res)
	);

	assign accept = start && (state_q == S_IDLE);
	assign rem2 = {rem_q, year_q[bit_q]};
	assign leap = gda_pkg::leap_of(rem_q);
	assign len = gda_pkg::days_in(month_q, leap);
	assign len_next = gda_pkg::days_in(month_q + 4'd1, leap);
	assign rest1 = {1'b0, len} - {1'b0, day_q} + 6'd1;
	assign rem_inc = (rem_q == 9'(gda_pkg::YearCycle - 10'd1)) ? 9'd0 : rem_q + 9'd1;

	// Feed the shared subtractor: year residue while reducing, day count while stepping
	always_comb begin
		if (state_q == S_MOD) begin
			alu_a = gda_pkg::AluW'(rem2);
			alu_b = gda_pkg::AluW'(gda_pkg::YearCycle);
		end else begin
			alu_a = gda_pkg::AluW'(left_q);
			alu_b = gda_pkg::AluW'(rest1);
		end
	end

	// Sequence one word: reduce year, check, then step month by month
	always_comb begin
		state_nx = state_q;
		year_nx = year_q;
		month_nx = month_q;
		day_nx = day_q;
		left_nx = left_q;
		rem_nx = rem_q;
		fin = 1'b0;
		fin_year = year_q;
		fin_month = month_q;
		fin_day = day_q;
		fin_status = gda_pkg::StatusOk;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nx = S_MOD;
					year_nx = in_year;
					month_nx = in_month;
					day_nx = in_day;
					left_nx = day_count;
					rem_nx = 9'd0;
				end
			end
			S_MOD: begin
				rem_nx = alu_res.borrow ? rem2[8:0] : alu_res.diff[8:0];
				if (bit_q == 4'd0) begin
					state_nx = S_CHECK;
				end
			end
			S_CHECK: begin
				if (year_q == 15'd0 || len == 5'd0 || day_q == 5'd0 || day_q > len) begin
					fin = 1'b1;
					fin_status = gda_pkg::StatusInvalid;
					state_nx = S_IDLE;
				end else if (func_q == gda_pkg::FuncAddMonth) begin
					fin = 1'b1;
					state_nx = S_IDLE;
					if (month_q == gda_pkg::MonthDec) begin
						if (year_q == gda_pkg::YearMax) begin
							fin_month = gda_pkg::MonthDec;
							fin_day = 5'd31;
							fin_status = gda_pkg::StatusOverflow;
						end else begin
							fin_year = year_q + 15'd1;
							fin_month = gda_pkg::MonthJan;
						end
					end else begin
						fin_month = month_q + 4'd1;
						fin_day = (day_q > len_next) ? len_next : day_q;
					end
				end else begin
					state_nx = S_STEP;
				end
			end
			S_STEP: begin
				if (left_q == '0) begin
					fin = 1'b1;
					state_nx = S_IDLE;
				end else if (alu_res.borrow) begin
					// count ends inside this month
					fin = 1'b1;
					fin_day = day_q + left_q[4:0];
					state_nx = S_IDLE;
				end else begin
					left_nx = alu_res.diff[gda_pkg::CountWidth-1:0];
					day_nx = 5'd1;
					if (month_q == gda_pkg::MonthDec) begin
						if (year_q == gda_pkg::YearMax) begin
							fin = 1'b1;
							fin_month = gda_pkg::MonthDec;
							fin_day = 5'd31;
							fin_status = gda_pkg::StatusOverflow;
							state_nx = S_IDLE;
						end else begin
							year_nx = year_q + 15'd1;
							month_nx = gda_pkg::MonthJan;
							rem_nx = rem_inc;
						end
					end else begin
						month_nx = month_q + 4'd1;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q <= fin;
		end
	end

	// Working and result registers
	always_ff @(posedge clk) begin
		year_q <= year_nx;
		month_q <= month_nx;
		day_q <= day_nx;
		left_q <= left_nx;
		rem_q <= rem_nx;
		if (accept) begin
			func_q <= func;
			bit_q <= 4'd14;
		end else if (state_q == S_MOD) begin
			bit_q <= bit_q - 4'd1;
		end
		if (fin) begin
			out_year_q <= fin_year;
			out_month_q <= fin_month;
			out_day_q <= fin_day;
			status_q <= fin_status;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign out_year = out_year_q;
	assign out_month = out_month_q;
	assign out_day = out_day_q;
	assign status = status_q;

`ifndef SYNTHESIS
	// a result only shows once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an accepted word starts the year reduction
	a_accept_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_MOD))
		else $error("accepted word did not start reduction");

	// year residue stays reduced
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK || state_q == S_STEP) |-> (rem_q < 9'd400))
		else $error("year residue out of range");

	// overflow saturates at the last representable day
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == gda_pkg::StatusOverflow) |->
		(out_year == gda_pkg::YearMax && out_month == gda_pkg::MonthDec && out_day == 5'd31))
		else $error("overflow result not saturated");

	// status never takes the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == gda_pkg::StatusOk || status == gda_pkg::StatusInvalid ||
			status == gda_pkg::StatusOverflow))
		else $error("unused status code");
`endif

endmodule

`default_nettype wire
